// ===== sv/fir_pll_bit_recovery_nrzi_defines.svh =====
// assertion macros for the nrzi bit recovery block
// used by the port checker; expects clk and rst_n in scope
`ifndef FIR_PLL_BIT_RECOVERY_NRZI_DEFINES_SVH
`define FIR_PLL_BIT_RECOVERY_NRZI_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FPBR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define FPBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fpbr_pkg.sv =====
// shared constants, types and coefficient function for the nrzi bit recovery block
// no dependencies
package fpbr_pkg;

  localparam int TAPS           = 36;
  localparam int COEF_FRAC_BITS = 15;
  localparam int COEF_COUNT     = 6;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 1;
  localparam int ACC_W          = SAMPLE_W + COEF_W + $clog2(TAPS);
  localparam int PHASE_W        = 16;
  localparam int NUDGE_SHIFT    = 4;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [PHASE_W-1:0] PHASE_RESET_INC = PHASE_W'(32'h10000 / 5);

  localparam logic [0:0] REG_PHASE_INC = 1'b0;

  // gaussian magnitudes in q30
  localparam longint COEF_Q30 [COEF_COUNT] = '{
    64'd875335810, 64'd385462577, 64'd74749611, 64'd6383180, 64'd240035, 64'd3975
  };

  typedef struct packed {
    logic go;
    logic level;
  } pll_in_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input int i);
    int     d;
    int     k;
    longint q;
    d = 2 * i - (TAPS - 1);
    if (d < 0) begin
      d = -d;
    end
    k = d >> 1;
    if (k >= COEF_COUNT) begin
      return '0;
    end
    q = (COEF_Q30[k] + (longint'(1) << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);
    return COEF_W'(q);
  endfunction

endpackage

// ===== sv/fpbr_cell.sv =====
// one multiply-add cell of the transposed fir chain
// depends on fpbr_pkg
module fpbr_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic signed [fpbr_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [fpbr_pkg::COEF_W-1:0]    coef,
  input  logic signed [fpbr_pkg::ACC_W-1:0]     sum_in,
  output logic signed [fpbr_pkg::ACC_W-1:0]     sum_out
);
  import fpbr_pkg::*;

  logic signed [SAMPLE_W+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]           sum_nxt;
  logic signed [ACC_W-1:0]           sum_r;

  assign prod    = sample * coef;
  assign sum_nxt = sum_in + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (en) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_out = sum_r;

endmodule

// ===== sv/fpbr_pll.sv =====
// zero-crossing phase tracker, nrzi decoder and output register
// depends on fpbr_pkg
module fpbr_pll (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fpbr_pkg::pll_in_t              ctl,
  input  logic [fpbr_pkg::PHASE_W-1:0]   phase_inc,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_data_bit,
  output logic                           out_free
);
  import fpbr_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               prev_sign_r, prev_sign_nxt;
  logic               last_bit_r, last_bit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_bit_r, out_bit_nxt;
  logic [PHASE_W-1:0] nudge;
  logic [PHASE_W-1:0] phase_adj;
  logic [PHASE_W:0]   phase_sum;
  logic               crossing;
  logic               wrap;

  assign nudge     = phase_inc >> NUDGE_SHIFT;
  assign crossing  = ctl.level ^ prev_sign_r;
  assign phase_sum = {1'b0, phase_adj} + {1'b0, phase_inc};
  assign wrap      = phase_sum[PHASE_W];
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (!crossing) begin
      phase_adj = phase_r;
    end else if (phase_r[PHASE_W-1]) begin
      phase_adj = phase_r - nudge;
    end else begin
      phase_adj = phase_r + nudge;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    prev_sign_nxt = prev_sign_r;
    last_bit_nxt  = last_bit_r;
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.go) begin
      phase_nxt     = phase_sum[PHASE_W-1:0];
      prev_sign_nxt = ctl.level;
      if (wrap) begin
        last_bit_nxt  = ctl.level;
        out_valid_nxt = 1'b1;
        out_bit_nxt   = ~(ctl.level ^ last_bit_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      prev_sign_r <= 1'b0;
      last_bit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      prev_sign_r <= prev_sign_nxt;
      last_bit_r  <= last_bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r <= out_bit_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_bit = out_bit_r;

endmodule

// ===== sv/fir_pll_bit_recovery_nrzi.sv =====
// path: a bit caused by a sample is registered in the cell chain, then in the phase
// tracker and output register; a stalled output can hold it between the two
// throughput: one sample per cycle unless the output stalls, set by the cell chain
// reset: synchronous, clears the chain, phase state and output valid; increment to 13107
// top level of the nrzi bit recovery block; depends on fpbr_pkg, fpbr_cell, fpbr_pll
module fir_pll_bit_recovery_nrzi (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fpbr_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_data_bit,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fpbr_pkg::PADDR_W-1:0]          paddr,
  input  logic [fpbr_pkg::PDATA_W-1:0]          pwdata,
  output logic [fpbr_pkg::PDATA_W-1:0]          prdata,
  output logic                                  pready
);
  import fpbr_pkg::*;

  logic signed [ACC_W-1:0] chain [TAPS+1];
  logic                    accept;
  logic                    filt_valid_r, filt_valid_nxt;
  logic [PHASE_W-1:0]      phase_inc_r, phase_inc_nxt;
  logic                    reg_hit;
  logic                    out_free;
  pll_in_t                 pll_in;

  assign chain[TAPS] = '0;
  assign accept      = in_valid && in_ready;

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    fpbr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (accept),
      .sample  (in_sample),
      .coef    (coef_at(j)),
      .sum_in  (chain[j+1]),
      .sum_out (chain[j])
    );
  end

  assign pll_in.go    = filt_valid_r && out_free;
  assign pll_in.level = ~chain[0][ACC_W-1] & (|chain[0]);
  assign in_ready     = !filt_valid_r || pll_in.go;

  always_comb begin
    filt_valid_nxt = filt_valid_r;
    if (accept) begin
      filt_valid_nxt = 1'b1;
    end else if (pll_in.go) begin
      filt_valid_nxt = 1'b0;
    end
  end

  assign reg_hit = (paddr[PADDR_W-1] == REG_PHASE_INC);

  always_comb begin
    phase_inc_nxt = phase_inc_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      phase_inc_nxt = pwdata[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_valid_r <= 1'b0;
      phase_inc_r  <= PHASE_RESET_INC;
    end else begin
      filt_valid_r <= filt_valid_nxt;
      phase_inc_r  <= phase_inc_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_hit ? PDATA_W'(phase_inc_r) : '0;

  fpbr_pll u_pll (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (pll_in),
    .phase_inc    (phase_inc_r),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data_bit (out_data_bit),
    .out_free     (out_free)
  );

endmodule

// ===== sv/fpbr_checker.sv =====
// port-level checker for the nrzi bit recovery block, bound to the top level
// depends on fir_pll_bit_recovery_nrzi_defines.svh
`include "fir_pll_bit_recovery_nrzi_defines.svh"

module fpbr_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_data_bit,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  `FPBR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_bit), "result changed while stalled")

  `FPBR_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled with output empty")

  `FPBR_ASSERT_IMPL(a_result_after_transfer, $rose(out_valid), $past(in_valid && in_ready, 2), "result without input transfer")

  `FPBR_ASSERT_IMPL(a_cfg_readback, $past(psel && penable && pwrite && !paddr[2]) && !paddr[2] && rst_n && $past(rst_n), prdata == {16'h0000, $past(pwdata[15:0])}, "increment readback mismatch")

endmodule

bind fir_pll_bit_recovery_nrzi fpbr_port_props u_fpbr_checker (.*);
